// File: rtl/itsf_pkg.sv
// Package of types, constants and the sequencer program for the IMU tilt and shake filter.
package itsf_pkg;

  // Fixed-point unity values.
  localparam int unsigned ONE_Q14 = 16384;
  localparam int unsigned ONE_Q16 = 65536;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SMOOTHING_GAIN = 3'd0;
  localparam logic [2:0] CFG_TILT_DECAY     = 3'd1;
  localparam logic [2:0] CFG_SHAKE_DECAY    = 3'd2;
  localparam logic [2:0] CFG_SHAKE_DAMPING  = 3'd3;
  localparam logic [2:0] CFG_IMPULSE_GAIN   = 3'd4;

  // Configuration reset values.
  localparam logic [7:0]  RST_SMOOTHING_GAIN = 8'd8;
  localparam logic [15:0] RST_TILT_DECAY     = 16'd60293;
  localparam logic [15:0] RST_SHAKE_DECAY    = 16'd56361;
  localparam logic [15:0] RST_SHAKE_DAMPING  = 16'd36045;
  localparam logic [15:0] RST_IMPULSE_GAIN   = 16'd32768;

  // Program counter width and entry points of the program.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_START = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INV   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FIN   = 4'd11;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DT_GAIN,
    MUL_TX_TDEC,
    MUL_TY_TDEC,
    MUL_SH_SDEC,
    MUL_DX_W,
    MUL_DY_W,
    MUL_W_DAMP,
    MUL_ACC_IMP,
    MUL_SH_W
  } mul_sel_t;

  // Destination of the registered product.
  typedef enum logic [3:0] {
    WB_NONE,
    WB_ALPHA,
    WB_TX,
    WB_TY,
    WB_DAMP,
    WB_IMP,
    WB_SH_VALID,
    WB_TX_DEC,
    WB_TY_DEC,
    WB_SH_DEC
  } wb_sel_t;

  // Sequencing of the step counter.
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_DT_ZERO,
    JMP_INVALID,
    JMP_ALWAYS,
    JMP_FINISH
  } jmp_t;

  typedef struct packed {
    mul_sel_t          mul;
    wb_sel_t           wb;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Control store. A product issued in one step is written back in the next.
  function automatic ctrl_word_t prog_rom(input logic [STEP_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{mul: MUL_NONE, wb: WB_NONE, jmp: JMP_FINISH, target: STEP_FIN};
    unique case (pc)
      4'd0:  cw = '{mul: MUL_DT_GAIN, wb: WB_NONE,     jmp: JMP_DT_ZERO, target: STEP_FIN};
      4'd1:  cw = '{mul: MUL_TX_TDEC, wb: WB_ALPHA,    jmp: JMP_INVALID, target: STEP_INV};
      4'd2:  cw = '{mul: MUL_DX_W,    wb: WB_NONE,     jmp: JMP_NEXT,    target: STEP_FIN};
      4'd3:  cw = '{mul: MUL_DY_W,    wb: WB_TX,       jmp: JMP_NEXT,    target: STEP_FIN};
      4'd4:  cw = '{mul: MUL_W_DAMP,  wb: WB_TY,       jmp: JMP_NEXT,    target: STEP_FIN};
      4'd5:  cw = '{mul: MUL_ACC_IMP, wb: WB_DAMP,     jmp: JMP_NEXT,    target: STEP_FIN};
      4'd6:  cw = '{mul: MUL_SH_W,    wb: WB_IMP,      jmp: JMP_NEXT,    target: STEP_FIN};
      4'd7:  cw = '{mul: MUL_NONE,    wb: WB_SH_VALID, jmp: JMP_ALWAYS,  target: STEP_FIN};
      4'd8:  cw = '{mul: MUL_TY_TDEC, wb: WB_TX_DEC,   jmp: JMP_NEXT,    target: STEP_FIN};
      4'd9:  cw = '{mul: MUL_SH_SDEC, wb: WB_TY_DEC,   jmp: JMP_NEXT,    target: STEP_FIN};
      4'd10: cw = '{mul: MUL_NONE,    wb: WB_SH_DEC,   jmp: JMP_ALWAYS,  target: STEP_FIN};
      default: cw = '{mul: MUL_NONE, wb: WB_NONE, jmp: JMP_FINISH, target: STEP_FIN};
    endcase
    return cw;
  endfunction

endpackage

// File: rtl/itsf_if.sv
// Valid/ready channel interfaces for the sample and result beats.
interface itsf_in_if;
  logic               valid;
  logic               ready;
  logic               sample_valid;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic [15:0]        time_step;

  modport source (output valid, sample_valid, accel_x, accel_y, time_step, input ready);
  modport sink   (input valid, sample_valid, accel_x, accel_y, time_step, output ready);
endinterface

interface itsf_out_if;
  logic               valid;
  logic               ready;
  logic               available_flag;
  logic signed [15:0] tilt_x_out;
  logic signed [15:0] tilt_y_out;
  logic [14:0]        shake_level;

  modport source (output valid, available_flag, tilt_x_out, tilt_y_out, shake_level,
                  input ready);
  modport sink   (input valid, available_flag, tilt_x_out, tilt_y_out, shake_level,
                  output ready);
endinterface

// File: rtl/imu_tilt_shake_filter.sv
// Top level of the IMU tilt and shake filter: microcoded sequencer around one multiplier.
//
//   channel  | direction | beat contents
//   ---------+-----------+------------------------------------------------------
//   in_ch    | sink      | sample_valid, accel_x, accel_y, time_step
//   out_ch   | source    | available_flag, tilt_x_out, tilt_y_out, shake_level
//   cfg_*    | write     | cfg_we, cfg_addr (register index), cfg_wdata
//
// A valid sample runs the update steps, an invalid sample jumps to the decay steps and a
// zero time step jumps to the final step; no new beat is taken before the last is done.
// The single 18x17 multiplier sets the pace; the steps share it one product at a time.
// Reset is synchronous and active low; it restores the register defaults and clears the
// filter state at once. A result waits in the output register while the next beat is
// taken; the sequencer only stalls in its final step while that register is still full.
module imu_tilt_shake_filter (
  input  logic        clk,
  input  logic        rst_n,
  itsf_in_if.sink     in_ch,
  itsf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers.
  logic [7:0]  gain_r;
  logic [15:0] tdec_r;
  logic [15:0] sdec_r;
  logic [15:0] damp_cfg_r;
  logic [15:0] imp_cfg_r;

  // Filter state.
  logic signed [15:0] tx_r, tx_nxt;
  logic signed [15:0] ty_r, ty_nxt;
  logic [14:0]        sh_r, sh_nxt;
  logic               av_r, av_nxt;

  // Sequencer.
  logic                        busy_r;
  logic [itsf_pkg::STEP_W-1:0] pc_r;
  itsf_pkg::ctrl_word_t        cw;

  // Latched beat and datapath registers.
  logic               sv_r;
  logic signed [15:0] ax_r, ay_r;
  logic [15:0]        dt_r;
  logic signed [35:0] p_r;
  logic [16:0]        w_r, w_nxt;     // alpha, later the shake damping factor
  logic [16:0]        acc_r, acc_nxt; // summed tilt change, later the impulse

  // Output register.
  logic               out_valid_r;
  logic               out_av_r;
  logic signed [15:0] out_tx_r, out_ty_r;
  logic [14:0]        out_sh_r;

  logic in_fire, out_free, finish;

  assign in_ch.ready = !busy_r;
  assign in_fire     = in_ch.valid && !busy_r;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign cw          = itsf_pkg::prog_rom(pc_r);
  assign finish      = busy_r && (cw.jmp == itsf_pkg::JMP_FINISH) && out_free;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.available_flag = out_av_r;
  assign out_ch.tilt_x_out     = out_tx_r;
  assign out_ch.tilt_y_out     = out_ty_r;
  assign out_ch.shake_level    = out_sh_r;

  // Clamp the latched samples to plus or minus one and form the tilt errors.
  logic signed [15:0] nx, ny;
  logic signed [16:0] dx, dy;

  always_comb begin
    if (ax_r > 16'sd16384) begin
      nx = 16'sd16384;
    end else if (ax_r < -16'sd16384) begin
      nx = -16'sd16384;
    end else begin
      nx = ax_r;
    end
    if (ay_r > 16'sd16384) begin
      ny = 16'sd16384;
    end else if (ay_r < -16'sd16384) begin
      ny = -16'sd16384;
    end else begin
      ny = ay_r;
    end
    dx = {nx[15], nx} - {tx_r[15], tx_r};
    dy = {ny[15], ny} - {ty_r[15], ty_r};
  end

  // Shared multiplier: signed 18-bit operand times unsigned 17-bit operand.
  logic signed [17:0] mul_a;
  logic [16:0]        mul_b;
  logic signed [35:0] prod;

  always_comb begin
    unique case (cw.mul)
      itsf_pkg::MUL_DT_GAIN: begin
        mul_a = {2'b00, dt_r};
        mul_b = {9'd0, gain_r};
      end
      itsf_pkg::MUL_TX_TDEC: begin
        mul_a = {{2{tx_r[15]}}, tx_r};
        mul_b = {1'b0, tdec_r};
      end
      itsf_pkg::MUL_TY_TDEC: begin
        mul_a = {{2{ty_r[15]}}, ty_r};
        mul_b = {1'b0, tdec_r};
      end
      itsf_pkg::MUL_SH_SDEC: begin
        mul_a = {3'b000, sh_r};
        mul_b = {1'b0, sdec_r};
      end
      itsf_pkg::MUL_DX_W: begin
        mul_a = {dx[16], dx};
        mul_b = w_r;
      end
      itsf_pkg::MUL_DY_W: begin
        mul_a = {dy[16], dy};
        mul_b = w_r;
      end
      itsf_pkg::MUL_W_DAMP: begin
        mul_a = {1'b0, w_r};
        mul_b = {1'b0, damp_cfg_r};
      end
      itsf_pkg::MUL_ACC_IMP: begin
        mul_a = {1'b0, acc_r};
        mul_b = {1'b0, imp_cfg_r};
      end
      itsf_pkg::MUL_SH_W: begin
        mul_a = {3'b000, sh_r};
        mul_b = w_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = 36'(mul_a) * 36'($signed({1'b0, mul_b}));
  end

  // Write-back of the registered product. Shifting the product right by 16 bits
  // through a part-select floors it, as the arithmetic is truncating.
  logic signed [15:0] t_old, t_new;
  logic signed [17:0] t_sum;
  logic signed [16:0] t_chg;
  logic [16:0]        t_abs;
  logic [17:0]        sh_sum;

  always_comb begin
    t_old  = (cw.wb == itsf_pkg::WB_TY) ? ty_r : tx_r;
    t_sum  = {{2{t_old[15]}}, t_old} + p_r[33:16];
    if (t_sum > 18'sd16384) begin
      t_new = 16'sd16384;
    end else if (t_sum < -18'sd16384) begin
      t_new = -16'sd16384;
    end else begin
      t_new = t_sum[15:0];
    end
    t_chg  = {t_new[15], t_new} - {t_old[15], t_old};
    t_abs  = t_chg[16] ? 17'(-t_chg) : t_chg;
    sh_sum = {3'b000, p_r[30:16]} + {1'b0, acc_r};

    tx_nxt  = tx_r;
    ty_nxt  = ty_r;
    sh_nxt  = sh_r;
    av_nxt  = av_r;
    w_nxt   = w_r;
    acc_nxt = acc_r;
    unique case (cw.wb)
      itsf_pkg::WB_NONE: begin
      end
      itsf_pkg::WB_ALPHA: begin
        w_nxt = (p_r > 36'sd65536) ? 17'd65536 : p_r[16:0];
      end
      itsf_pkg::WB_TX: begin
        tx_nxt  = t_new;
        acc_nxt = t_abs;
      end
      itsf_pkg::WB_TY: begin
        ty_nxt  = t_new;
        acc_nxt = acc_r + t_abs;
      end
      itsf_pkg::WB_DAMP: begin
        w_nxt = 17'd65536 - {1'b0, p_r[31:16]};
      end
      itsf_pkg::WB_IMP: begin
        acc_nxt = {1'b0, p_r[31:16]};
      end
      itsf_pkg::WB_SH_VALID: begin
        sh_nxt = (sh_sum > 18'd16384) ? 15'd16384 : sh_sum[14:0];
        av_nxt = 1'b1;
      end
      itsf_pkg::WB_TX_DEC: begin
        tx_nxt = p_r[31:16];
      end
      itsf_pkg::WB_TY_DEC: begin
        ty_nxt = p_r[31:16];
      end
      itsf_pkg::WB_SH_DEC: begin
        sh_nxt = p_r[30:16];
        av_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Next step of the program.
  logic [itsf_pkg::STEP_W-1:0] pc_nxt;

  always_comb begin
    unique case (cw.jmp)
      itsf_pkg::JMP_NEXT:    pc_nxt = pc_r + 4'd1;
      itsf_pkg::JMP_DT_ZERO: pc_nxt = (dt_r == 16'd0) ? cw.target : pc_r + 4'd1;
      itsf_pkg::JMP_INVALID: pc_nxt = !sv_r ? cw.target : pc_r + 4'd1;
      itsf_pkg::JMP_ALWAYS:  pc_nxt = cw.target;
      itsf_pkg::JMP_FINISH:  pc_nxt = pc_r;
      default:               pc_nxt = pc_r;
    endcase
  end

  // Control, configuration and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= itsf_pkg::RST_SMOOTHING_GAIN;
      tdec_r      <= itsf_pkg::RST_TILT_DECAY;
      sdec_r      <= itsf_pkg::RST_SHAKE_DECAY;
      damp_cfg_r  <= itsf_pkg::RST_SHAKE_DAMPING;
      imp_cfg_r   <= itsf_pkg::RST_IMPULSE_GAIN;
      tx_r        <= '0;
      ty_r        <= '0;
      sh_r        <= '0;
      av_r        <= 1'b0;
      busy_r      <= 1'b0;
      pc_r        <= itsf_pkg::STEP_START;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          itsf_pkg::CFG_SMOOTHING_GAIN: gain_r     <= cfg_wdata[7:0];
          itsf_pkg::CFG_TILT_DECAY:     tdec_r     <= cfg_wdata;
          itsf_pkg::CFG_SHAKE_DECAY:    sdec_r     <= cfg_wdata;
          itsf_pkg::CFG_SHAKE_DAMPING:  damp_cfg_r <= cfg_wdata;
          itsf_pkg::CFG_IMPULSE_GAIN:   imp_cfg_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (busy_r) begin
        tx_r <= tx_nxt;
        ty_r <= ty_nxt;
        sh_r <= sh_nxt;
        av_r <= av_nxt;
        pc_r <= pc_nxt;
      end

      if (in_fire) begin
        busy_r <= 1'b1;
        pc_r   <= itsf_pkg::STEP_START;
      end else if (finish) begin
        busy_r <= 1'b0;
      end

      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sv_r <= in_ch.sample_valid;
      ax_r <= in_ch.accel_x;
      ay_r <= in_ch.accel_y;
      dt_r <= in_ch.time_step;
    end
    if (busy_r) begin
      p_r   <= prod;
      w_r   <= w_nxt;
      acc_r <= acc_nxt;
    end
    if (finish) begin
      out_av_r <= av_r;
      out_tx_r <= tx_r;
      out_ty_r <= ty_r;
      out_sh_r <= sh_r;
    end
  end

`ifndef SYNTHESIS
  // The program never runs past its final step.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= itsf_pkg::STEP_FIN))
    else $error("sequencer step out of program range");

  // Shake and tilt stay within plus or minus one.
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sh_r <= 15'd16384) && (tx_r <= 16'sd16384) && (tx_r >= -16'sd16384)
    && (ty_r <= 16'sd16384) && (ty_r >= -16'sd16384))
    else $error("filter state out of range");

  // A result appears only after the final step of the program.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r && (pc_r == itsf_pkg::STEP_FIN)))
    else $error("result raised outside the final step");

  // An accepted beat starts the program at its first step.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (busy_r && (pc_r == itsf_pkg::STEP_START)))
    else $error("accepted beat did not start the program");
`endif

endmodule

// File: tb/sv/imu_tilt_shake_filter_chk.sv
// Watches the sample and result channels, predicts each filter reading and compares it.
module imu_tilt_shake_filter_chk
  import itsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  itsf_in_if          in_mon,
  itsf_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int unsigned mismatch_count,
  output int unsigned readings_due
);

  typedef struct packed {
    logic               avail;
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
    logic [14:0]        shake;
  } reading_t;

  // Shadow copy of the register file and the filter state.
  logic [7:0]         gain_q;
  logic [15:0]        tilt_decay_q;
  logic [15:0]        shake_decay_q;
  logic [15:0]        damping_q;
  logic [15:0]        impulse_q;
  logic               avail_q;
  logic signed [15:0] tilt_x_q;
  logic signed [15:0] tilt_y_q;
  logic [14:0]        shake_q;

  reading_t pending_readings[$];

  function automatic longint clamp_unit(input longint v);
    if (v < -longint'(ONE_Q14)) return -longint'(ONE_Q14);
    if (v > longint'(ONE_Q14)) return longint'(ONE_Q14);
    return v;
  endfunction

  // Applies one sample to the shadow state. Products are floored, as the block truncates.
  function automatic void advance_filter(input logic sv, input logic signed [15:0] ax,
                                         input logic signed [15:0] ay, input logic [15:0] dt);
    longint nx, ny, ox, oy, alpha, chg, damp, imp, sh_next;
    if (dt != '0) begin
      if (!sv) begin
        avail_q  = 1'b0;
        tilt_x_q = 16'((longint'(tilt_x_q) * longint'(tilt_decay_q)) >>> 16);
        tilt_y_q = 16'((longint'(tilt_y_q) * longint'(tilt_decay_q)) >>> 16);
        shake_q  = 15'((longint'(shake_q) * longint'(shake_decay_q)) >> 16);
      end else begin
        nx    = clamp_unit(longint'(ax));
        ny    = clamp_unit(longint'(ay));
        ox    = longint'(tilt_x_q);
        oy    = longint'(tilt_y_q);
        alpha = longint'(gain_q) * longint'(dt);
        if (alpha > longint'(ONE_Q16)) alpha = longint'(ONE_Q16);
        avail_q  = 1'b1;
        tilt_x_q = 16'(clamp_unit(ox + (((nx - ox) * alpha) >>> 16)));
        tilt_y_q = 16'(clamp_unit(oy + (((ny - oy) * alpha) >>> 16)));
        chg = longint'(tilt_x_q) - ox;
        if (chg < 0) chg = -chg;
        if (longint'(tilt_y_q) - oy < 0) chg = chg + oy - longint'(tilt_y_q);
        else chg = chg + longint'(tilt_y_q) - oy;
        damp    = longint'(ONE_Q16) - ((alpha * longint'(damping_q)) >> 16);
        imp     = (chg * longint'(impulse_q)) >> 16;
        sh_next = ((longint'(shake_q) * damp) >> 16) + imp;
        if (sh_next > longint'(ONE_Q14)) sh_next = longint'(ONE_Q14);
        shake_q = 15'(sh_next);
      end
    end
  endfunction

  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst_n) begin
      gain_q         = RST_SMOOTHING_GAIN;
      tilt_decay_q   = RST_TILT_DECAY;
      shake_decay_q  = RST_SHAKE_DECAY;
      damping_q      = RST_SHAKE_DAMPING;
      impulse_q      = RST_IMPULSE_GAIN;
      avail_q        = 1'b0;
      tilt_x_q       = '0;
      tilt_y_q       = '0;
      shake_q        = '0;
      pending_readings.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SMOOTHING_GAIN: gain_q        = cfg_wdata[7:0];
          CFG_TILT_DECAY:     tilt_decay_q  = cfg_wdata;
          CFG_SHAKE_DECAY:    shake_decay_q = cfg_wdata;
          CFG_SHAKE_DAMPING:  damping_q     = cfg_wdata;
          CFG_IMPULSE_GAIN:   impulse_q     = cfg_wdata;
          default: ;
        endcase
      end
      // A result taken at this edge can only belong to an earlier sample.
      if (out_mon.valid && out_mon.ready) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected result beat: avail %0b tilt_x %0d tilt_y %0d shake %0d",
                 out_mon.available_flag, out_mon.tilt_x_out, out_mon.tilt_y_out,
                 out_mon.shake_level);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_r = pending_readings.pop_front();
          if (out_mon.available_flag !== exp_r.avail ||
              out_mon.tilt_x_out !== exp_r.tilt_x ||
              out_mon.tilt_y_out !== exp_r.tilt_y ||
              out_mon.shake_level !== exp_r.shake)
            mismatch_count <= mismatch_count + 1;
          if (out_mon.available_flag !== exp_r.avail)
            $error("available_flag: expected %0b, got %0b", exp_r.avail,
                   out_mon.available_flag);
          if (out_mon.tilt_x_out !== exp_r.tilt_x)
            $error("tilt_x_out: expected %0d, got %0d", exp_r.tilt_x, out_mon.tilt_x_out);
          if (out_mon.tilt_y_out !== exp_r.tilt_y)
            $error("tilt_y_out: expected %0d, got %0d", exp_r.tilt_y, out_mon.tilt_y_out);
          if (out_mon.shake_level !== exp_r.shake)
            $error("shake_level: expected %0d, got %0d", exp_r.shake, out_mon.shake_level);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        advance_filter(in_mon.sample_valid, in_mon.accel_x, in_mon.accel_y,
                       in_mon.time_step);
        pending_readings.push_back('{avail: avail_q, tilt_x: tilt_x_q, tilt_y: tilt_y_q,
                                     shake: shake_q});
      end
    end
    readings_due <= pending_readings.size();
  end

endmodule

// File: tb/sv/imu_tilt_shake_filter_tb.sv
// Top of the IMU tilt and shake filter testbench: clock, reset, stimulus and verdict.
module imu_tilt_shake_filter_tb;
  import itsf_pkg::*;

  // Items per random phase; eight phases give roughly 1650 beats in all.
  localparam int PHASE_ITEMS = 205;
  // Cycles the receiver holds off in one long stall, enough to back the block up.
  localparam int LONG_HOLD = 200;
  // Pause before a register change; longer than a valid sample keeps the sequencer busy.
  localparam int SETTLE_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  int unsigned mismatch_count;
  int unsigned readings_due;

  // Both sides idle in short random bursts while this is set.
  bit gaps_on = 1'b1;
  // Each bump of hold_tickets asks the receiver for one long stall.
  int hold_tickets = 0;
  int hold_served = 0;

  itsf_in_if  in_ch ();
  itsf_out_if out_ch ();

  imu_tilt_shake_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  imu_tilt_shake_filter_chk filter_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .readings_due   (readings_due)
  );

  always #5 clk = ~clk;

  // Hard limit on the run. The slowest legal run is far below this: about 1700 beats,
  // each with its sequencer work, a sender gap and a receiver stall, plus one long
  // hold and a settling pause around each register change.
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result receiver. Ready changes only at the falling edge. It owns the counters of
  // the long hold so that the stall length does not depend on the sender.
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_tickets) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Offers one sample beat and holds it until the block takes it. Valid stays high into
  // the next beat unless a random gap is drawn.
  task automatic send_sample(input logic sv, input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] dt);
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.sample_valid = sv;
    in_ch.accel_x      = ax;
    in_ch.accel_y      = ay;
    in_ch.time_step    = dt;
    do @(posedge clk); while (!in_ch.ready);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3) - 1) @(negedge clk);
    end
  endtask

  // Withdraws the sample channel, then blocks until every predicted reading has been
  // taken from the block.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (readings_due != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
  endtask

  // Reprograms all five registers while the block is idle. A write to an index past the
  // register list goes first; the block must drop it.
  task automatic load_profile(input logic [7:0] gain, input logic [15:0] tdec,
                              input logic [15:0] sdec, input logic [15:0] damping,
                              input logic [15:0] impulse);
    wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write(3'(CFG_IMPULSE_GAIN + 3'd1 + 3'($urandom_range(0, 2))), 16'($urandom));
    // The gain register is eight bits wide; random upper bits must be ignored.
    cfg_write(CFG_SMOOTHING_GAIN, {8'($urandom), gain});
    cfg_write(CFG_TILT_DECAY, tdec);
    cfg_write(CFG_SHAKE_DECAY, sdec);
    cfg_write(CFG_SHAKE_DAMPING, damping);
    cfg_write(CFG_IMPULSE_GAIN, impulse);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random accelerometer component: mostly inside plus or minus one, with the
  // clamp edges and the full signed range mixed in.
  function automatic logic [15:0] pick_accel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'(int'($urandom_range(0, 2 * ONE_Q14)) - int'(ONE_Q14));
    if (r < 78) return ($urandom_range(0, 1) != 0) ? 16'(ONE_Q14) : 16'(-int'(ONE_Q14));
    return 16'($urandom);
  endfunction

  // Most beats are valid samples at realistic steps so that tilt and shake build up;
  // zero steps, invalid samples and huge steps are the minority.
  task automatic send_random_sample();
    int r;
    logic [15:0] dt;
    r = $urandom_range(0, 99);
    if (r < 5) dt = '0;
    else if (r < 60) dt = 16'($urandom_range(1, 512));
    else if (r < 85) dt = 16'($urandom_range(1, 8192));
    else dt = 16'($urandom);
    send_sample($urandom_range(0, 99) >= 15, pick_accel(), pick_accel(), dt);
  endtask

  initial begin
    int ph;
    int n;
    in_ch.valid        = 1'b0;
    in_ch.sample_valid = 1'b0;
    in_ch.accel_x      = '0;
    in_ch.accel_y      = '0;
    in_ch.time_step    = '0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed beats at the reset register values.
    send_sample(1'b1, 16'd0, 16'd0, 16'd0);                  // zero step right after reset
    send_sample(1'b1, 16'd16384, -16'sd16384, 16'd8192);     // weight exactly one
    send_sample(1'b1, 16'h7FFF, 16'h8000, 16'hFFFF);         // clamp and saturated weight
    send_sample(1'b1, 16'h8000, 16'h7FFF, 16'hFFFF);         // full swing, shake overflow
    send_sample(1'b0, 16'($urandom), 16'($urandom), 16'd1);  // invalid sample decays
    send_sample(1'b0, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_sample(1'b0, 16'h7FFF, 16'h7FFF, 16'd0);            // invalid with zero step
    send_sample(1'b1, 16'd16385, -16'sd16385, 16'd1);        // just past the clamp
    send_sample(1'b1, 16'd16383, -16'sd16383, 16'd8193);     // weight just over one
    send_sample(1'b1, 16'd0, 16'd0, 16'd100);
    send_sample(1'b1, 16'hFFFF, 16'd1, 16'd1);
    send_sample(1'b1, 16'd1, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'h8000, 16'h7FFF, 16'd0);            // zero step keeps state
    repeat (4) send_sample(1'b0, 16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
    send_sample(1'b1, 16'd5000, -16'sd7000, 16'd300);
    send_sample(1'b1, -16'sd12000, 16'd9000, 16'd2000);

    // Random phases, each with its own register setting. Phase zero keeps the reset
    // values; the all-zero and all-ones settings cover the register extremes.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        1: load_profile(8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: load_profile(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: load_profile(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
        4: load_profile(8'($urandom_range(1, 16)), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
        5: load_profile(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
        6: load_profile(8'hFF, 16'($urandom), 16'($urandom), 16'hFFFF, 16'hFFFF);
        7: load_profile(RST_SMOOTHING_GAIN, RST_TILT_DECAY, RST_SHAKE_DECAY,
                        RST_SHAKE_DAMPING, RST_IMPULSE_GAIN);
        default: ;
      endcase
      // The closing phase runs with both sides streaming at full rate.
      if (ph == 7) gaps_on = 1'b0;
      // A long receiver stall while beats keep coming fills the result register and
      // pushes back on the sample channel.
      if (ph == 2) hold_tickets++;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          // Sender pause mid-phase until the block has handed back everything.
          wait_drained();
          @(negedge clk);
          in_ch.valid = 1'b0;
        end
        send_random_sample();
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && readings_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
